@@ src/lru_key_value_cache_assert.svh @@
// ---------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms used by the cache's checker.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Checked on every rising edge once reset has been released.
`define LRUKV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, during reset as well.
`define LRUKV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lrukv_pkg.sv @@
// ---------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, item types and codes shared by the cache modules.
// ---------------------------------------------------------------------------
package lrukv_pkg;

	localparam int ENTRIES = 16;
	localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic signed [31:0] READ_MISS = -32'sd1;

	typedef enum logic {
		ACT_LOOKUP = 1'b0,
		ACT_WRITE  = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] read_value;
	} out_item_t;

endpackage

@@ src/lrukv_core.sv @@
// ---------------------------------------------------------------------------
// LRU key-value cache core
// Entry store with parallel key match, recency ranks and replacement.
// ---------------------------------------------------------------------------
module lrukv_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  lrukv_pkg::in_item_t             item,
	input  logic [lrukv_pkg::CAP_W-1:0]     capacity,
	output lrukv_pkg::out_item_t            result
);

	logic [lrukv_pkg::ENTRIES-1:0]                          valid_q;
	logic signed [31:0]                                     key_q  [lrukv_pkg::ENTRIES];
	logic signed [31:0]                                     data_q [lrukv_pkg::ENTRIES];
	logic [lrukv_pkg::RANK_W-1:0]                           rank_q [lrukv_pkg::ENTRIES];
	logic [lrukv_pkg::CNT_W-1:0]                            occ_q;

	logic [lrukv_pkg::ENTRIES-1:0] hit_vec;
	logic [lrukv_pkg::ENTRIES-1:0] victim_vec;
	logic [lrukv_pkg::ENTRIES-1:0] free_vec;
	logic [lrukv_pkg::ENTRIES-1:0] tgt_vec;
	logic                          hit;
	logic                          full;
	logic                          is_write;
	logic                          do_update;
	logic                          do_insert;
	logic [lrukv_pkg::RANK_W-1:0]  hit_rank;
	logic signed [31:0]            hit_data;
	logic [lrukv_pkg::CMP_W-1:0]   eff_cap;
	logic [lrukv_pkg::CNT_W-1:0]   ref_rank;
	logic [lrukv_pkg::CNT_W-1:0]   last_rank;

	assign is_write  = (item.action == lrukv_pkg::ACT_WRITE);
	assign last_rank = occ_q - lrukv_pkg::CNT_W'(1);

	always_comb begin
		hit_rank = '0;
		hit_data = '0;
		for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
			hit_vec[i]    = valid_q[i] && (key_q[i] == item.key);
			victim_vec[i] = valid_q[i] && (lrukv_pkg::CNT_W'(rank_q[i]) == last_rank);
			hit_rank      = hit_rank | (rank_q[i] & {lrukv_pkg::RANK_W{hit_vec[i]}});
			hit_data      = hit_data | (data_q[i] & {32{hit_vec[i]}});
		end
		hit = |hit_vec;
	end

	always_comb begin
		logic taken;
		taken = 1'b0;
		for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
			free_vec[i] = !valid_q[i] && !taken;
			taken       = taken || !valid_q[i];
		end
	end

	always_comb begin
		if (capacity == '0) begin
			eff_cap = lrukv_pkg::CMP_W'(1);
		end else if (lrukv_pkg::CMP_W'(capacity) > lrukv_pkg::CMP_W'(lrukv_pkg::ENTRIES)) begin
			eff_cap = lrukv_pkg::CMP_W'(lrukv_pkg::ENTRIES);
		end else begin
			eff_cap = lrukv_pkg::CMP_W'(capacity);
		end
	end

	assign full = (lrukv_pkg::CMP_W'(occ_q) >= eff_cap);

	always_comb begin
		priority if (hit) begin
			tgt_vec  = hit_vec;
			ref_rank = lrukv_pkg::CNT_W'(hit_rank);
		end else if (full) begin
			tgt_vec  = victim_vec;
			ref_rank = last_rank;
		end else begin
			tgt_vec  = free_vec;
			ref_rank = occ_q;
		end
	end

	assign do_update = fire && (hit || is_write);
	assign do_insert = fire && is_write && !hit && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (do_insert) begin
			valid_q <= valid_q | free_vec;
			occ_q   <= occ_q + lrukv_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
			if (do_update) begin
				if (tgt_vec[i]) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (lrukv_pkg::CNT_W'(rank_q[i]) < ref_rank)) begin
					rank_q[i] <= rank_q[i] + lrukv_pkg::RANK_W'(1);
				end
			end
			if (fire && is_write && tgt_vec[i]) begin
				key_q[i]  <= item.key;
				data_q[i] <= item.value;
			end
		end
	end

	always_comb begin
		result.found = hit;
		unique case (item.action)
			lrukv_pkg::ACT_LOOKUP: result.read_value = hit ? hit_data : lrukv_pkg::READ_MISS;
			lrukv_pkg::ACT_WRITE:  result.read_value = '0;
			default:               result.read_value = '0;
		endcase
	end

endmodule

@@ src/lru_key_value_cache.sv @@
// Path: an accepted item is loaded into the input register, and its result is loaded
// into the result register when no result is waiting there.
// Throughput: one item per cycle while the consumer takes every result; while a result
// waits, the input register takes one more item and then the input stalls.
// Reset: asynchronous, active low; the store empties and capacity returns to 16.
// ---------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ---------------------------------------------------------------------------
module lru_key_value_cache (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lrukv_pkg::in_item_t         in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lrukv_pkg::out_item_t        out_item,
	input  logic                        cfg_wr_en,
	input  logic [lrukv_pkg::CAP_W-1:0] cfg_wr_data
);

	lrukv_pkg::in_item_t         item_s1;
	logic                        valid_s1;
	lrukv_pkg::out_item_t        result;
	lrukv_pkg::out_item_t        out_item_q;
	logic                        out_valid_q;
	logic [lrukv_pkg::CAP_W-1:0] cap_q;
	logic                        advance;
	logic                        fire;

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lrukv_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (fire) begin
			out_item_q <= result;
		end
	end

	lrukv_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.capacity (cap_q),
		.result   (result)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ src/lrukv_checker.sv @@
// ---------------------------------------------------------------------------
// LRU key-value cache checker
// Port-level assertions on the cache, attached to every instance by bind.
// ---------------------------------------------------------------------------
`include "lru_key_value_cache_assert.svh"

module lrukv_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input lrukv_pkg::out_item_t        out_item
);

	// A stalled result must stay put until it is taken.
	`LRUKV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "result changed while stalled")
	// Every accepted item leaves a result waiting once it has passed the input register.
	`LRUKV_ASSERT(a_in_to_out, in_valid && in_ready |=> ##1 out_valid, "accepted item produced no result")
	// The input side only stalls behind a result the consumer is holding back.
	`LRUKV_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")
	// No result is offered while reset is held.
	`LRUKV_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result offered during reset")

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (.*);

@@ sim/tb_lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives lookups and writes through the cache in directed and random phases
// at several capacity settings, predicts every result with a local model of
// the least-recently-used store and checks each result in order.
// ---------------------------------------------------------------------------
module tb_lru_key_value_cache;

	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE   = 24;

	typedef enum int {
		RX_STEADY,
		RX_COIN,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	logic                        clk         = 1'b0;
	logic                        arst_n;
	logic                        in_valid    = 1'b0;
	logic                        in_ready;
	lrukv_pkg::in_item_t         in_item     = '0;
	logic                        out_valid;
	logic                        out_ready   = 1'b0;
	lrukv_pkg::out_item_t        out_item;
	logic                        cfg_wr_en   = 1'b0;
	logic [lrukv_pkg::CAP_W-1:0] cfg_wr_data = '0;

	lrukv_pkg::in_item_t  pending_items[$];
	lrukv_pkg::out_item_t expected_results[$];

	int items_offered = 0;
	int items_taken   = 0;
	int results_seen  = 0;
	int errors        = 0;
	int cycles        = 0;

	int burst_left = 1;
	int gap_left   = 0;

	rx_mode_t rx_mode   = RX_STEADY;
	int       mode_left = 0;
	int       hold_left = 0;
	logic     hold_done = 1'b0;

	logic                        line_valid [lrukv_pkg::ENTRIES];
	logic signed [31:0]          line_key   [lrukv_pkg::ENTRIES];
	logic signed [31:0]          line_data  [lrukv_pkg::ENTRIES];
	int unsigned                 line_rank  [lrukv_pkg::ENTRIES];
	int unsigned                 occupancy  = 0;
	logic [lrukv_pkg::CAP_W-1:0] capacity   = lrukv_pkg::CAP_RESET;

	logic signed [31:0] key_pool [POOL_SIZE];

	lru_key_value_cache DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	function automatic int effective_capacity(logic [lrukv_pkg::CAP_W-1:0] cap);
		if (cap == 0)
			return 1;
		if (cap > lrukv_pkg::ENTRIES)
			return lrukv_pkg::ENTRIES;
		return int'(cap);
	endfunction

	function automatic void make_newest(int s);
		int unsigned r;
		r = line_rank[s];
		for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
			if (line_valid[i] && line_rank[i] < r)
				line_rank[i]++;
		line_rank[s] = 0;
	endfunction

	function automatic lrukv_pkg::out_item_t cache_access(lrukv_pkg::in_item_t it);
		lrukv_pkg::out_item_t res;
		int                   hit;
		int                   victim;
		int                   slot;
		int unsigned          worst;
		hit = -1;
		for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
			if (hit < 0 && line_valid[i] && line_key[i] == it.key)
				hit = i;
		res.found = (hit >= 0);
		if (it.action == lrukv_pkg::ACT_LOOKUP) begin
			res.read_value = (hit >= 0) ? line_data[hit] : lrukv_pkg::READ_MISS;
			if (hit >= 0)
				make_newest(hit);
		end else begin
			res.read_value = '0;
			if (hit >= 0) begin
				line_data[hit] = it.value;
				make_newest(hit);
			end else if (occupancy >= effective_capacity(capacity)) begin
				victim = -1;
				worst = 0;
				for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
					if (line_valid[i] && (victim < 0 || line_rank[i] > worst)) begin
						victim = i;
						worst = line_rank[i];
					end
				if (victim >= 0) begin
					line_key[victim] = it.key;
					line_data[victim] = it.value;
					make_newest(victim);
				end
			end else begin
				slot = -1;
				for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
					if (slot < 0 && !line_valid[i])
						slot = i;
				if (slot >= 0) begin
					for (int i = 0; i < lrukv_pkg::ENTRIES; i++)
						if (line_valid[i])
							line_rank[i]++;
					line_valid[slot] = 1'b1;
					line_key[slot] = it.key;
					line_data[slot] = it.value;
					line_rank[slot] = 0;
					occupancy++;
				end
			end
		end
		return res;
	endfunction

	function automatic lrukv_pkg::in_item_t make_item(lrukv_pkg::action_t a,
			logic signed [31:0] k, logic signed [31:0] v);
		lrukv_pkg::in_item_t it;
		it.action = a;
		it.key = k;
		it.value = v;
		return it;
	endfunction

	function automatic lrukv_pkg::in_item_t random_item(int span);
		logic signed [31:0] k;
		if ($urandom_range(0, 99) < 85)
			k = key_pool[$urandom_range(0, span - 1)];
		else
			k = $urandom;
		return make_item(lrukv_pkg::action_t'($urandom_range(0, 1)), k, $urandom);
	endfunction

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || items_offered != items_taken ||
			items_taken != results_seen);
	endtask

	task automatic write_capacity(logic [lrukv_pkg::CAP_W-1:0] cap);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(logic [lrukv_pkg::CAP_W-1:0] cap, int n);
		int span;
		write_capacity(cap);
		span = effective_capacity(cap) + $urandom_range(2, 8);
		if (span > POOL_SIZE)
			span = POOL_SIZE;
		repeat (n)
			pending_items.push_back(random_item(span));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		lrukv_pkg::out_item_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result found=%0b read_value=%0d", $time,
						out_item.found, out_item.read_value);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (out_item.found !== want.found) begin
						$display("%0t: found mismatch, expected %0b actual %0b", $time,
							want.found, out_item.found);
						errors++;
					end
					if (out_item.read_value !== want.read_value) begin
						$display("%0t: read_value mismatch, expected %0d actual %0d",
							$time, want.read_value, out_item.read_value);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(cache_access(in_item));
				items_taken <= items_taken + 1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && items_offered == items_taken) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				in_item <= pending_items.pop_front();
				in_valid <= 1'b1;
				items_offered <= items_offered + 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && results_seen >= 300 && pending_items.size() > 40) begin
			hold_done <= 1'b1;
			hold_left <= 150;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(10, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_STEADY: out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
				default:   out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		arst_n <= 1'b0;
		for (int i = 0; i < lrukv_pkg::ENTRIES; i++) begin
			line_valid[i] = 1'b0;
			line_key[i] = '0;
			line_data[i] = '0;
			line_rank[i] = 0;
		end
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 32'sh0000_0000;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, 32'sh0, 32'sh0));
		pending_items.push_back(make_item(lrukv_pkg::ACT_WRITE, 32'sh8000_0000,
			32'sh7fff_ffff));
		pending_items.push_back(make_item(lrukv_pkg::ACT_WRITE, 32'sh7fff_ffff,
			32'sh8000_0000));
		pending_items.push_back(make_item(lrukv_pkg::ACT_WRITE, 32'sh0, 32'sh0));
		pending_items.push_back(make_item(lrukv_pkg::ACT_WRITE, -32'sd1, -32'sd1));
		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, 32'sh8000_0000, 32'sh0));
		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, 32'sh8000_0000, -32'sd1));
		pending_items.push_back(make_item(lrukv_pkg::ACT_WRITE, 32'sh7fff_ffff,
			32'sh1234_5678));
		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, 32'sh7fff_ffff, 32'sh0));
		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, 32'sh5555_5555,
			32'shaaaa_aaaa));

		// The store holds four entries, so a capacity of two leaves it over full.
		write_capacity(5'd2);
		pending_items.push_back(make_item(lrukv_pkg::ACT_WRITE, 32'sh5555_5555,
			32'sh0000_0001));
		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, 32'sh0, 32'sh0));
		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, -32'sd1, 32'sh0));
		pending_items.push_back(make_item(lrukv_pkg::ACT_WRITE, 32'sh0000_002a,
			32'sh2a2a_2a2a));
		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, 32'sh8000_0000, 32'sh0));

		write_capacity(5'd0);
		pending_items.push_back(make_item(lrukv_pkg::ACT_WRITE, 32'sh7, 32'sh7));
		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, 32'sh7, 32'sh0));
		pending_items.push_back(make_item(lrukv_pkg::ACT_WRITE, 32'sh8, 32'sh8));
		pending_items.push_back(make_item(lrukv_pkg::ACT_LOOKUP, 32'sh7, 32'sh0));

		random_phase(5'd31, 100);
		random_phase(5'd16, 100);
		random_phase(5'd5, 100);
		random_phase(5'd1, 100);
		random_phase(5'd9, 100);
		random_phase(5'd17, 100);
		random_phase(5'd3, 100);
		random_phase(5'd16, 100);
		random_phase(5'd12, 100);
		random_phase(5'd24, 100);

		wait_idle();
		repeat (8) @(negedge clk);
		if (expected_results.size() != 0)
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/lrukv_pkg.sv
src/lrukv_core.sv
src/lru_key_value_cache.sv
src/lrukv_checker.sv
sim/tb_lru_key_value_cache.sv
